// ===== sv/hsb2rgb_pkg.sv =====
// Shared types for the HSB to RGB converter: hue sectors and stage control.
package hsb2rgb_pkg;

  // Hue sector, hue * 6 rounded down; six colour wheel segments
  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_t;

  // Control that travels alongside each request through the pipeline
  typedef struct packed {
    logic    valid;
    sector_t sector;
  } stage_ctl_t;

endpackage

// ===== sv/hsb2rgb_prep.sv =====
// Stage 1: clamp saturation and brightness, split hue * 6 into sector and fraction.
module hsb2rgb_prep import hsb2rgb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [FRAC_BITS-1:0] hue,
  input  logic [FRAC_BITS:0]   saturation,
  input  logic [FRAC_BITS:0]   brightness,
  output stage_ctl_t           ctl_o,
  output logic [FRAC_BITS:0]   sat_o,
  output logic [FRAC_BITS:0]   bri_o,
  output logic [FRAC_BITS-1:0] frac_o
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [FRAC_BITS+2:0] hue6;
  stage_ctl_t           ctl_r, ctl_nxt;
  logic [FRAC_BITS:0]   sat_r, sat_nxt;
  logic [FRAC_BITS:0]   bri_r, bri_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;

  // hue * 6 as (hue << 2) + (hue << 1)
  assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  always_comb begin
    ctl_nxt.valid  = in_valid;
    ctl_nxt.sector = sector_t'(hue6[FRAC_BITS+2:FRAC_BITS]);
    frac_nxt       = hue6[FRAC_BITS-1:0];
    sat_nxt        = (saturation > ONE) ? ONE : saturation;
    bri_nxt        = (brightness > ONE) ? ONE : brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r  <= sat_nxt;
      bri_r  <= bri_nxt;
      frac_r <= frac_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign sat_o  = sat_r;
  assign bri_o  = bri_r;
  assign frac_o = frac_r;

endmodule

// ===== sv/hsb2rgb_coef.sv =====
// Stage 2: form the three brightness scale factors 1-s, 1-s*f and 1-s*(1-f).
module hsb2rgb_coef import hsb2rgb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  stage_ctl_t           ctl_i,
  input  logic [FRAC_BITS:0]   sat_i,
  input  logic [FRAC_BITS:0]   bri_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output stage_ctl_t           ctl_o,
  output logic [FRAC_BITS:0]   bri_o,
  output logic [FRAC_BITS:0]   k_p_o,
  output logic [FRAC_BITS:0]   k_q_o,
  output logic [FRAC_BITS:0]   k_t_o
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [FRAC_BITS:0]     om_frac;
  logic [2*FRAC_BITS:0]   sf_prod;
  logic [2*FRAC_BITS+1:0] st_prod;
  stage_ctl_t             ctl_r;
  logic [FRAC_BITS:0]     bri_r;
  logic [FRAC_BITS:0]     k_p_r, k_p_nxt;
  logic [FRAC_BITS:0]     k_q_r, k_q_nxt;
  logic [FRAC_BITS:0]     k_t_r, k_t_nxt;

  assign om_frac = ONE - {1'b0, frac_i};
  assign sf_prod = sat_i * frac_i;
  assign st_prod = sat_i * om_frac;

  // Both truncated products stay within 0..ONE, so F+1 bits hold them
  always_comb begin
    k_p_nxt = ONE - sat_i;
    k_q_nxt = ONE - sf_prod[2*FRAC_BITS:FRAC_BITS];
    k_t_nxt = ONE - st_prod[2*FRAC_BITS:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bri_r <= bri_i;
      k_p_r <= k_p_nxt;
      k_q_r <= k_q_nxt;
      k_t_r <= k_t_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign bri_o = bri_r;
  assign k_p_o = k_p_r;
  assign k_q_o = k_q_r;
  assign k_t_o = k_t_r;

endmodule

// ===== sv/hsb2rgb_mult.sv =====
// Stage 3: scale brightness by each factor to give p, q and t.
module hsb2rgb_mult import hsb2rgb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  stage_ctl_t         ctl_i,
  input  logic [FRAC_BITS:0] bri_i,
  input  logic [FRAC_BITS:0] k_p_i,
  input  logic [FRAC_BITS:0] k_q_i,
  input  logic [FRAC_BITS:0] k_t_i,
  output stage_ctl_t         ctl_o,
  output logic [FRAC_BITS:0] bri_o,
  output logic [FRAC_BITS:0] p_o,
  output logic [FRAC_BITS:0] q_o,
  output logic [FRAC_BITS:0] t_o
);

  logic [2*FRAC_BITS+1:0] p_prod, q_prod, t_prod;
  stage_ctl_t             ctl_r;
  logic [FRAC_BITS:0]     bri_r, p_r, q_r, t_r;

  assign p_prod = bri_i * k_p_i;
  assign q_prod = bri_i * k_q_i;
  assign t_prod = bri_i * k_t_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  // Products never exceed brightness, so the top bit of each is dropped
  always_ff @(posedge clk) begin
    if (adv) begin
      bri_r <= bri_i;
      p_r   <= p_prod[2*FRAC_BITS:FRAC_BITS];
      q_r   <= q_prod[2*FRAC_BITS:FRAC_BITS];
      t_r   <= t_prod[2*FRAC_BITS:FRAC_BITS];
    end
  end

  assign ctl_o = ctl_r;
  assign bri_o = bri_r;
  assign p_o   = p_r;
  assign q_o   = q_r;
  assign t_o   = t_r;

endmodule

// ===== sv/hsb2rgb_place.sv =====
// Stage 4: route brightness, p, q and t onto the channels by sector; output register.
module hsb2rgb_place import hsb2rgb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  stage_ctl_t         ctl_i,
  input  logic [FRAC_BITS:0] bri_i,
  input  logic [FRAC_BITS:0] p_i,
  input  logic [FRAC_BITS:0] q_i,
  input  logic [FRAC_BITS:0] t_i,
  output logic               valid_o,
  output logic [FRAC_BITS:0] red_o,
  output logic [FRAC_BITS:0] green_o,
  output logic [FRAC_BITS:0] blue_o
);

  logic               valid_r;
  logic [FRAC_BITS:0] red_r, red_nxt;
  logic [FRAC_BITS:0] green_r, green_nxt;
  logic [FRAC_BITS:0] blue_r, blue_nxt;

  always_comb begin
    unique case (ctl_i.sector)
      SECT_RY: begin
        red_nxt = bri_i; green_nxt = t_i;   blue_nxt = p_i;
      end
      SECT_YG: begin
        red_nxt = q_i;   green_nxt = bri_i; blue_nxt = p_i;
      end
      SECT_GC: begin
        red_nxt = p_i;   green_nxt = bri_i; blue_nxt = t_i;
      end
      SECT_CB: begin
        red_nxt = p_i;   green_nxt = q_i;   blue_nxt = bri_i;
      end
      SECT_BM: begin
        red_nxt = t_i;   green_nxt = p_i;   blue_nxt = bri_i;
      end
      default: begin
        red_nxt = bri_i; green_nxt = p_i;   blue_nxt = q_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign valid_o = valid_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;

endmodule

// ===== sv/hsb_to_rgb_converter_top.sv =====
// HSB to RGB converter top level: four register stages, clamp, factors, products, placement.
// An accepted request passes the clamp, factor, product and placement registers in turn to the out_ port.
// Throughput: one request per cycle; the whole pipeline holds while a valid output is stalled.
// The factor stage (subtract, FRAC_BITS+1 square product, subtract) sets the per-stage depth.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
module hsb_to_rgb_converter_top import hsb2rgb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS-1:0] in_hue,
  input  logic [FRAC_BITS:0]   in_saturation,
  input  logic [FRAC_BITS:0]   in_brightness,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_BITS:0]   out_red,
  output logic [FRAC_BITS:0]   out_green,
  output logic [FRAC_BITS:0]   out_blue
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic                 adv;
  stage_ctl_t           ctl1, ctl2, ctl3;
  logic [FRAC_BITS:0]   sat1, bri1, bri2, bri3;
  logic [FRAC_BITS-1:0] frac1;
  logic [FRAC_BITS:0]   k_p2, k_q2, k_t2;
  logic [FRAC_BITS:0]   p3, q3, t3;

  // Whole pipe moves unless a finished result is being held back
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  hsb2rgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .ctl_o      (ctl1),
    .sat_o      (sat1),
    .bri_o      (bri1),
    .frac_o     (frac1)
  );

  hsb2rgb_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_i  (ctl1),
    .sat_i  (sat1),
    .bri_i  (bri1),
    .frac_i (frac1),
    .ctl_o  (ctl2),
    .bri_o  (bri2),
    .k_p_o  (k_p2),
    .k_q_o  (k_q2),
    .k_t_o  (k_t2)
  );

  hsb2rgb_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (ctl2),
    .bri_i (bri2),
    .k_p_i (k_p2),
    .k_q_i (k_q2),
    .k_t_i (k_t2),
    .ctl_o (ctl3),
    .bri_o (bri3),
    .p_o   (p3),
    .q_o   (q3),
    .t_o   (t3)
  );

  // Zero saturation needs no special path: all factors are then 1.0 (grey)
  hsb2rgb_place #(.FRAC_BITS(FRAC_BITS)) u_place (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_i   (ctl3),
    .bri_i   (bri3),
    .p_i     (p3),
    .q_i     (q3),
    .t_i     (t3),
    .valid_o (out_valid),
    .red_o   (out_red),
    .green_o (out_green),
    .blue_o  (out_blue)
  );

`ifndef NO_ASSERTIONS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= ONE && out_green <= ONE && out_blue <= ONE))
    else $error("output channel above 1.0");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ctl1.valid)
    else $error("accepted request did not enter stage 1");

  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    ctl1.valid |-> (ctl1.sector <= SECT_MR))
    else $error("hue sector out of range");

  a_pqt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl3.valid |-> (p3 <= bri3 && q3 <= bri3 && t3 <= bri3))
    else $error("scaled term exceeds brightness");
`endif

endmodule
